### rtl/prpsw_pkg.sv
package prpsw_pkg;

  localparam int PAGE_LOG2_MIN   = 12;
  localparam int PAGE_LOG2_MAX   = 16;
  localparam int PAGE_LOG2_RESET = 12;
  localparam int ENTRY_BYTES     = 8;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic MODE_CMD        = 1'b0;
  localparam logic MODE_ENTRY      = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_MANY = 1'b1;

  typedef struct packed {
    logic        seg_valid;
    logic [63:0] seg_address;
    logic [16:0] seg_length;
    logic [8:0]  seg_number;
    logic [31:0] running_total;
    logic        misaligned;
    logic [63:0] fetch_address;
    logic        awaiting_entry;
    logic        status;
    logic        last;
  } res_t;

  // One classified request: one result, or two when the command spans two pages.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } job_t;

endpackage

### rtl/prpsw_front.sv
module prpsw_front #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [4:0]          page_size_log2,
  input  logic                push,
  input  logic                q_full,
  input  logic                in_mode,
  input  logic [63:0]         in_first_pointer,
  input  logic [63:0]         in_second_pointer,
  input  logic [31:0]         in_transfer_length,
  input  logic [63:0]         in_entry_address,
  output logic                full,
  output logic                job_push,
  output prpsw_pkg::job_t     job
);

  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic        active_r, active_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] bytes_done_r, bytes_done_nxt;
  logic [63:0] fetch_r, fetch_nxt;
  logic [CW-1:0] seg_cnt_r, seg_cnt_nxt;

  logic        accept;
  logic [4:0]  sh;
  logic [16:0] page;
  logic [15:0] pmask;
  logic [16:0] room;
  logic [32:0] room_two;
  logic [31:0] rem;
  logic [16:0] chunk;
  logic [31:0] left_e;
  logic [31:0] done_e;
  logic [CW-1:0] cnt_inc;
  logic [CW+8:0] num_wide;
  logic        mis_e;
  logic        mis_p2;

  assign full     = q_full;
  assign accept   = push & ~q_full;
  assign job_push = accept & ((in_mode == prpsw_pkg::MODE_CMD) | active_r);

  always_comb begin
    if (page_size_log2 < 5'(prpsw_pkg::PAGE_LOG2_MIN)) begin
      sh = 5'(prpsw_pkg::PAGE_LOG2_MIN);
    end else if (page_size_log2 > 5'(prpsw_pkg::PAGE_LOG2_MAX)) begin
      sh = 5'(prpsw_pkg::PAGE_LOG2_MAX);
    end else begin
      sh = page_size_log2;
    end
  end

  assign page     = 17'd1 << sh;
  assign pmask    = 16'(page - 17'd1);
  assign room     = page - {1'b0, in_first_pointer[15:0] & pmask};
  assign room_two = {16'b0, room} + {16'b0, page};
  assign rem      = in_transfer_length - {15'b0, room};
  assign mis_p2   = |(in_second_pointer[15:0] & pmask);

  assign chunk    = (bytes_left_r < {15'b0, page}) ? bytes_left_r[16:0] : page;
  assign left_e   = bytes_left_r - {15'b0, chunk};
  assign done_e   = bytes_done_r + {15'b0, chunk};
  assign cnt_inc  = seg_cnt_r + CW'(1);
  assign num_wide = {9'b0, seg_cnt_r};
  assign mis_e    = |(in_entry_address[15:0] & pmask);

  always_comb begin
    job            = '0;
    active_nxt     = active_r;
    bytes_left_nxt = bytes_left_r;
    bytes_done_nxt = bytes_done_r;
    fetch_nxt      = fetch_r;
    seg_cnt_nxt    = seg_cnt_r;
    if (in_mode == prpsw_pkg::MODE_CMD) begin
      active_nxt     = 1'b0;
      bytes_left_nxt = '0;
      bytes_done_nxt = '0;
      fetch_nxt      = '0;
      seg_cnt_nxt    = '0;
      if (in_transfer_length == 32'd0) begin
        job.r0.last = 1'b1;
      end else if (in_transfer_length <= {15'b0, room}) begin
        job.r0.seg_valid     = 1'b1;
        job.r0.seg_address   = in_first_pointer;
        job.r0.seg_length    = in_transfer_length[16:0];
        job.r0.running_total = in_transfer_length;
        job.r0.last          = 1'b1;
      end else begin
        job.r0.seg_valid     = 1'b1;
        job.r0.seg_address   = in_first_pointer;
        job.r0.seg_length    = room;
        job.r0.running_total = {15'b0, room};
        if ({1'b0, in_transfer_length} <= room_two) begin
          job.two              = 1'b1;
          job.r1.seg_valid     = 1'b1;
          job.r1.seg_address   = in_second_pointer;
          job.r1.seg_length    = rem[16:0];
          job.r1.seg_number    = 9'd1;
          job.r1.running_total = in_transfer_length;
          job.r1.misaligned    = mis_p2;
          job.r1.last          = 1'b1;
        end else begin
          job.r0.fetch_address  = in_second_pointer;
          job.r0.awaiting_entry = 1'b1;
          active_nxt     = 1'b1;
          bytes_left_nxt = rem;
          bytes_done_nxt = {15'b0, room};
          fetch_nxt      = in_second_pointer + 64'(prpsw_pkg::ENTRY_BYTES);
          seg_cnt_nxt    = CW'(1);
        end
      end
    end else if (active_r) begin
      job.r0.seg_valid     = 1'b1;
      job.r0.seg_address   = in_entry_address;
      job.r0.seg_length    = chunk;
      job.r0.seg_number    = num_wide[8:0];
      job.r0.running_total = done_e;
      job.r0.misaligned    = mis_e;
      bytes_left_nxt = left_e;
      bytes_done_nxt = done_e;
      seg_cnt_nxt    = cnt_inc;
      if (left_e == 32'd0) begin
        job.r0.last = 1'b1;
        active_nxt  = 1'b0;
      end else if (cnt_inc >= CW'(MAX_SEGMENTS)) begin
        job.r0.status = prpsw_pkg::STATUS_TOO_MANY;
        job.r0.last   = 1'b1;
        active_nxt    = 1'b0;
      end else begin
        job.r0.fetch_address  = fetch_r;
        job.r0.awaiting_entry = 1'b1;
        fetch_nxt = fetch_r + 64'(prpsw_pkg::ENTRY_BYTES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      bytes_left_r <= '0;
      bytes_done_r <= '0;
      fetch_r      <= '0;
      seg_cnt_r    <= '0;
    end else if (accept) begin
      active_r     <= active_nxt;
      bytes_left_r <= bytes_left_nxt;
      bytes_done_r <= bytes_done_nxt;
      fetch_r      <= fetch_nxt;
      seg_cnt_r    <= seg_cnt_nxt;
    end
  end

endmodule

### rtl/prpsw_queue.sv
module prpsw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  prpsw_pkg::job_t wr_data,
  input  logic            rd_en,
  output prpsw_pkg::job_t rd_data,
  output logic            full,
  output logic            empty
);

  localparam int DEPTH = prpsw_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  prpsw_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

endmodule

### rtl/prpsw_back.sv
module prpsw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  prpsw_pkg::job_t q_job,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output prpsw_pkg::res_t res
);

  prpsw_pkg::res_t out_res_r;
  prpsw_pkg::res_t pend_res_r;
  logic            out_valid_r;
  logic            pend_r;
  logic            load;

  // The output register may be refilled in the same cycle its result is taken.
  assign load  = ~out_valid_r | pop;
  assign q_pop = load & ~pend_r & ~q_empty;
  assign empty = ~out_valid_r;
  assign res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (!q_empty) begin
        out_valid_r <= 1'b1;
        pend_r      <= q_job.two;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_res_r <= pend_res_r;
      end else if (!q_empty) begin
        out_res_r  <= q_job.r0;
        pend_res_r <= q_job.r1;
      end
    end
  end

endmodule

### rtl/prp_segment_walker.sv
// Channel   Handshake              Payload
// input     push / full            in_mode, in_first_pointer, in_second_pointer,
//                                  in_transfer_length, in_entry_address
// result    empty / pop            out_seg_valid ... out_last (one result per pop)
// config    cfg_wr_en              cfg_wr_data (page_size_log2)
//
// One request is accepted per cycle while the four-entry job queue has room.
// A request's results pass through the job queue and then the output register;
// a command that covers two pages gives its two results from the output stage
// one after the other, every other queued request one.
// Reset (rst_n low, synchronous) empties the queue and output stage, ends any
// walk and sets page_size_log2 to 12. Either side may stall without loss.
module prp_segment_walker #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic        in_mode,
  input  logic [63:0] in_first_pointer,
  input  logic [63:0] in_second_pointer,
  input  logic [31:0] in_transfer_length,
  input  logic [63:0] in_entry_address,
  output logic        empty,
  input  logic        pop,
  output logic        out_seg_valid,
  output logic [63:0] out_seg_address,
  output logic [16:0] out_seg_length,
  output logic [8:0]  out_seg_number,
  output logic [31:0] out_running_total,
  output logic        out_misaligned,
  output logic [63:0] out_fetch_address,
  output logic        out_awaiting_entry,
  output logic        out_status,
  output logic        out_last
);

  logic [4:0]      page_size_log2_r;
  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  prpsw_pkg::job_t push_job;
  prpsw_pkg::job_t head_job;
  prpsw_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_log2_r <= 5'(prpsw_pkg::PAGE_LOG2_RESET);
    end else if (cfg_wr_en) begin
      page_size_log2_r <= cfg_wr_data;
    end
  end

  prpsw_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .page_size_log2     (page_size_log2_r),
    .push               (push),
    .q_full             (q_full),
    .in_mode            (in_mode),
    .in_first_pointer   (in_first_pointer),
    .in_second_pointer  (in_second_pointer),
    .in_transfer_length (in_transfer_length),
    .in_entry_address   (in_entry_address),
    .full               (full),
    .job_push           (q_push),
    .job                (push_job)
  );

  prpsw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (push_job),
    .rd_en   (q_pop),
    .rd_data (head_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  prpsw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (head_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_seg_valid      = res.seg_valid;
  assign out_seg_address    = res.seg_address;
  assign out_seg_length     = res.seg_length;
  assign out_seg_number     = res.seg_number;
  assign out_running_total  = res.running_total;
  assign out_misaligned     = res.misaligned;
  assign out_fetch_address  = res.fetch_address;
  assign out_awaiting_entry = res.awaiting_entry;
  assign out_status         = res.status;
  assign out_last           = res.last;

endmodule
